### src/ipv_lru_pkg.sv
// shared constants, types and helpers for the ipv lru replacement block
// no dependencies; compiled first
package ipv_lru_pkg;

   localparam int WAYS   = 16;
   localparam int SETS   = 64;
   localparam int POS_W  = $clog2(WAYS + 1);
   localparam int WAY_W  = 4;
   localparam int SIDX_W = 6;
   localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int LEAVES = 16;
   localparam int TREE_LV = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      OP_TOUCH  = 2'd0,
      OP_INSERT = 2'd1,
      OP_INVAL  = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_PROMOTE_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROMOTE_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INSERT_POS   = 2'd2;

   localparam logic [31:0] PROMOTE_LOW_RST  = 32'h2303_0100;
   localparam logic [31:0] PROMOTE_HIGH_RST = 32'hB400_1501;
   localparam logic [3:0]  INSERT_POS_RST   = 4'd8;

   localparam logic [POS_W-1:0] POS_INVALID = POS_W'(WAYS);
   localparam logic [POS_W-1:0] POS_OLDEST  = POS_W'(WAYS - 1);

   typedef logic [WAYS-1:0][POS_W-1:0] row_type;

   // saturate a 4-bit target to the oldest valid position
   function automatic logic [POS_W-1:0] clamp_pos(input logic [3:0] p);
      logic [POS_W-1:0] pe;
      begin
         pe = POS_W'(p);
         clamp_pos = (pe >= POS_INVALID) ? POS_OLDEST : pe;
      end
   endfunction

endpackage

### src/ipv_lru_if.sv
// valid/ready channel interfaces for request, response and csr writes
// depends on ipv_lru_pkg
interface ipv_lru_req_if;
   logic                            valid;
   logic                            ready;
   ipv_lru_pkg::op_type             op;
   logic [ipv_lru_pkg::SIDX_W-1:0]  set_index;
   logic [ipv_lru_pkg::WAY_W-1:0]   way;
   modport source (output valid, op, set_index, way, input ready);
   modport sink   (input valid, op, set_index, way, output ready);
endinterface

interface ipv_lru_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ipv_lru_pkg::WAY_W-1:0]  victim_way;
   logic [ipv_lru_pkg::POS_W-1:0]  victim_position;
   modport source (output valid, victim_way, victim_position, input ready);
   modport sink   (input valid, victim_way, victim_position, output ready);
endinterface

interface ipv_lru_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ipv_lru_pkg::CSR_IDX_W-1:0]  index;
   logic [ipv_lru_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/ipv_lru_replacement_top.sv
// ipv lru replacement: per-set recency positions kept in one row-wide memory
// the row read is registered with the request; the update state writes row and response
// one item at a time (one row read-modify-write each); no request is taken in the update state
// a new request is taken while the previous response waits in the output register
// reset (synchronous): csrs to defaults, all row valid bits cleared so every way reads invalid
// depends on ipv_lru_pkg and the ipv_lru interfaces
module ipv_lru_replacement_top (
   input  logic          clock,
   input  logic          reset,
   ipv_lru_req_if.sink   req_chan,
   ipv_lru_rsp_if.source rsp_chan,
   ipv_lru_csr_if.sink   csr_chan
);
   import ipv_lru_pkg::*;

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type state_ff;

   // csr registers
   logic [31:0] promote_low_ff;
   logic [31:0] promote_high_ff;
   logic [3:0]  insert_pos_ff;

   // captured request
   op_type             op_ff;
   logic [SET_W-1:0]   set_ff;
   logic [WAY_W-1:0]   way_ff;
   logic               set_ok_ff;
   logic               way_ok_ff;

   // row memory and per-row valid bits
   logic [$bits(row_type)-1:0] mem [SETS];
   logic [SETS-1:0]  row_valid_ff;
   row_type          rd_row_ff;
   logic             rd_valid_ff;

   // response register
   logic               rsp_valid_ff;
   logic [WAY_W-1:0]   victim_way_ff;
   logic [POS_W-1:0]   victim_pos_ff;

   logic             req_fire;
   logic             exec_done;
   logic             wr_en;
   logic [SET_W-1:0] rd_addr;
   row_type          row_cur;
   row_type          row_new;
   logic [63:0]      promote_vec;
   logic [POS_W-1:0] ins_pos;
   logic [POS_W-1:0] cur_pos;
   logic [POS_W-1:0] tgt_pos;
   logic [POS_W-1:0] tp [TREE_LV+1][LEAVES];
   logic [WAY_W-1:0] tw [TREE_LV+1][LEAVES];
   logic [WAY_W-1:0] best_way;
   logic [POS_W-1:0] best_pos;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign exec_done = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);
   assign rd_addr   = SET_W'(req_chan.set_index);
   assign wr_en     = exec_done && set_ok_ff && way_ok_ff && (op_ff != OP_QUERY);

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.victim_way      = victim_way_ff;
   assign rsp_chan.victim_position = victim_pos_ff;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         promote_low_ff  <= PROMOTE_LOW_RST;
         promote_high_ff <= PROMOTE_HIGH_RST;
         insert_pos_ff   <= INSERT_POS_RST;
      end else if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.index)
            CSR_PROMOTE_LOW:  promote_low_ff  <= csr_chan.data;
            CSR_PROMOTE_HIGH: promote_high_ff <= csr_chan.data;
            CSR_INSERT_POS:   insert_pos_ff   <= csr_chan.data[3:0];
            default: ;
         endcase
      end
   end

   // request capture and registered row read
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= req_chan.op;
         set_ff    <= rd_addr;
         way_ff    <= req_chan.way;
         set_ok_ff <= ({1'b0, req_chan.set_index} < (SIDX_W + 1)'(SETS));
         way_ok_ff <= ({1'b0, req_chan.way} < (WAY_W + 1)'(WAYS));
         rd_row_ff <= mem[rd_addr];
      end
   end

   // row write-back
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[set_ff] <= row_new;
      end
   end

   // row valid bits, captured alongside the read
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
         if (wr_en) begin
            row_valid_ff[set_ff] <= 1'b1;
         end
      end
   end

   // effective row: unwritten or out-of-range sets read as all invalid
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         row_cur[i] = (rd_valid_ff && set_ok_ff) ? rd_row_ff[i] : POS_INVALID;
      end
   end

   // target selection
   assign promote_vec = {promote_high_ff, promote_low_ff};
   assign ins_pos     = clamp_pos(insert_pos_ff);

   always_comb begin
      cur_pos = row_cur[way_ff[$clog2(WAYS)-1:0]];
      if (cur_pos >= POS_INVALID) begin
         cur_pos = POS_INVALID;
         tgt_pos = ins_pos;
      end else begin
         tgt_pos = clamp_pos(promote_vec[{cur_pos[3:0], 2'b00} +: 4]);
      end
   end

   // per-way update, one lane per way
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         row_new[i] = row_cur[i];
         case (op_ff)
            OP_TOUCH: begin
               if (i == int'(way_ff)) begin
                  row_new[i] = tgt_pos;
               end else if (tgt_pos <= cur_pos) begin
                  if (row_cur[i] >= tgt_pos && row_cur[i] < cur_pos) begin
                     row_new[i] = row_cur[i] + 1'b1;
                  end
               end else if (row_cur[i] > cur_pos && row_cur[i] <= tgt_pos) begin
                  row_new[i] = row_cur[i] - 1'b1;
               end
            end
            OP_INSERT: begin
               if (i == int'(way_ff)) begin
                  row_new[i] = ins_pos;
               end else if (row_cur[i] >= ins_pos && row_cur[i] < POS_INVALID) begin
                  row_new[i] = row_cur[i] + 1'b1;
               end
            end
            OP_INVAL: begin
               if (i == int'(way_ff)) begin
                  row_new[i] = POS_INVALID;
               end
            end
            default: ;
         endcase
      end
   end

   // victim search: max-position tree, left (lower way) wins ties
   always_comb begin
      for (int l = 0; l <= TREE_LV; l++) begin
         for (int k = 0; k < LEAVES; k++) begin
            tp[l][k] = '0;
            tw[l][k] = '0;
         end
      end
      for (int k = 0; k < WAYS; k++) begin
         tp[0][k] = row_cur[k];
         tw[0][k] = WAY_W'(k);
      end
      for (int k = WAYS; k < LEAVES; k++) begin
         tw[0][k] = WAY_W'(k);
      end
      for (int l = 0; l < TREE_LV; l++) begin
         for (int k = 0; k < (LEAVES >> (l + 1)); k++) begin
            if (tp[l][2*k+1] > tp[l][2*k]) begin
               tp[l+1][k] = tp[l][2*k+1];
               tw[l+1][k] = tw[l][2*k+1];
            end else begin
               tp[l+1][k] = tp[l][2*k];
               tw[l+1][k] = tw[l][2*k];
            end
         end
      end
      best_pos = tp[TREE_LV][0];
      best_way = tw[TREE_LV][0];
   end

   // control state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         victim_way_ff <= '0;
         victim_pos_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && !exec_done) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (exec_done) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
                  if (op_ff == OP_QUERY) begin
                     victim_way_ff <= best_way;
                     victim_pos_ff <= best_pos;
                  end else begin
                     victim_way_ff <= '0;
                     victim_pos_ff <= '0;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // checks
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_EXEC))
      else $error("request transfer did not start the update cycle");

   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> row_valid_ff[$past(set_ff)])
      else $error("written row not marked valid");

   a_victim_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (victim_pos_ff <= POS_INVALID))
      else $error("victim position beyond invalid marker");

   a_rsp_not_lost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> rsp_valid_ff)
      else $error("stalled response dropped");

endmodule

### sim/testbench.sv
// self-checking testbench for ipv_lru_replacement_top: recency, promotion and victim choice
// depends on ipv_lru_pkg, the ipv_lru channel interfaces and the rtl top level
`timescale 1ns / 100ps

module testbench;
   import ipv_lru_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 250;
   localparam int PRINT_LIMIT    = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [WAY_W-1:0] way;
      logic [POS_W-1:0] position;
   } victim_type;

   logic clock;
   logic reset;

   ipv_lru_req_if req_bus ();
   ipv_lru_rsp_if rsp_bus ();
   ipv_lru_csr_if csr_bus ();

   ipv_lru_replacement_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // mirror of the recency store and the csr settings
   logic [POS_W-1:0] recency [SETS][WAYS];
   logic [31:0]      promote_lo_q;
   logic [31:0]      promote_hi_q;
   logic [3:0]       insert_pos_q;

   victim_type victims_due[$];
   int      error_count = 0;
   int      rsp_count = 0;
   bit      no_idle = 1'b0;
   bit      hold_request = 1'b0;
   int      busy_sets[4];

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // one line per mismatch, printing capped, counting not
   task automatic report_mismatch(input string what, input logic [31:0] expected,
                                  input logic [31:0] got);
      if (error_count < PRINT_LIMIT)
         $display("%0t: %s mismatch: expected %0d, got %0d (response %0d)",
                  $realtime, what, expected, got, rsp_count);
      error_count++;
   endtask

   // predictor helpers
   function automatic int saturate_pos(input int p);
      return (p >= WAYS) ? WAYS - 1 : p;
   endfunction

   function automatic int promotion_for(input int cur);
      logic [31:0] word;
      word = (cur < 8) ? promote_lo_q : promote_hi_q;
      return saturate_pos(int'((word >> ((cur % 8) * 4)) & 32'hF));
   endfunction

   // move one way to a new position, shifting the ways in between
   function automatic void reposition(input int s, input int w, input int cur, input int tgt);
      int p;
      for (int i = 0; i < WAYS; i++) begin
         p = int'(recency[s][i]);
         if (i != w) begin
            if (tgt <= cur) begin
               if (p >= tgt && p < cur) recency[s][i] = POS_W'(p + 1);
            end else if (p > cur && p <= tgt) begin
               recency[s][i] = POS_W'(p - 1);
            end
         end
      end
      recency[s][w] = POS_W'(tgt);
   endfunction

   // update the mirror for one access and return the expected response
   function automatic victim_type predict_access(input op_type op, input int s, input int w);
      victim_type v;
      int      cur;
      int      tgt;
      int      best_w;
      int      best_p;
      int      ins;
      v = '0;
      case (op)
         OP_QUERY: begin
            best_w = 0;
            best_p = int'(recency[s][0]);
            for (int i = 1; i < WAYS; i++) begin
               if (recency[s][i] > best_p) begin
                  best_p = int'(recency[s][i]);
                  best_w = i;
               end
            end
            v.way      = WAY_W'(best_w);
            v.position = POS_W'(best_p);
         end
         OP_TOUCH: begin
            cur = int'(recency[s][w]);
            if (cur >= WAYS) begin
               cur = WAYS;
               tgt = saturate_pos(int'(insert_pos_q));
            end else begin
               tgt = promotion_for(cur);
            end
            reposition(s, w, cur, tgt);
         end
         OP_INSERT: begin
            ins = saturate_pos(int'(insert_pos_q));
            for (int i = 0; i < WAYS; i++) begin
               if (recency[s][i] >= ins && recency[s][i] < WAYS)
                  recency[s][i] = recency[s][i] + 1'b1;
            end
            recency[s][w] = POS_W'(ins);
         end
         OP_INVAL: begin
            recency[s][w] = POS_INVALID;
         end
         default: ;
      endcase
      return v;
   endfunction

   // sender gap length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // one request transfer; valid stays high until the next gap or pause
   task automatic send_access(input op_type op, input int s, input int w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.op        <= op;
      req_bus.set_index <= SIDX_W'(s);
      req_bus.way       <= WAY_W'(w);
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      victims_due.push_back(predict_access(op, s, w));
   endtask

   // sender pauses until every expected response is back
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (victims_due.size() != 0) @(posedge clock);
   endtask

   // one csr transfer, mirrored on acceptance
   task automatic write_register(input logic [CSR_IDX_W-1:0] index, input logic [31:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      case (index)
         CSR_PROMOTE_LOW:  promote_lo_q = data;
         CSR_PROMOTE_HIGH: promote_hi_q = data;
         CSR_INSERT_POS:   insert_pos_q = data[3:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // full reprogramming, only with the block drained
   task automatic apply_settings(input logic [31:0] lo, input logic [31:0] hi,
                                 input logic [31:0] ins);
      wait_for_results();
      write_register(CSR_PROMOTE_LOW, lo);
      write_register(CSR_SPARE, $urandom());
      write_register(CSR_PROMOTE_HIGH, hi);
      write_register(CSR_INSERT_POS, ins);
   endtask

   function automatic op_type pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return OP_TOUCH;
      if (r < 80) return OP_INSERT;
      if (r < 90) return OP_INVAL;
      return OP_QUERY;
   endfunction

   // mostly fill-and-use sequences on a few busy sets, the rest scattered noise
   task automatic run_random_traffic(input int count);
      int sent;
      int s;
      int n;
      int tmp;
      int j;
      int order[WAYS];
      sent = 0;
      foreach (busy_sets[i]) busy_sets[i] = $urandom_range(0, SETS - 1);
      while (sent < count) begin
         if ($urandom_range(0, 99) < 75) begin
            s = busy_sets[$urandom_range(0, 3)];
            if ($urandom_range(0, 3) == 0) begin
               // fill every way in shuffled order
               foreach (order[i]) order[i] = i;
               for (int i = WAYS - 1; i > 0; i--) begin
                  j = $urandom_range(0, i);
                  tmp = order[i];
                  order[i] = order[j];
                  order[j] = tmp;
               end
               foreach (order[i]) send_access(OP_INSERT, s, order[i]);
               sent += WAYS;
            end
            n = $urandom_range(4, 20);
            for (int k = 0; k < n; k++) begin
               send_access(pick_op(), s, $urandom_range(0, WAYS - 1));
            end
            send_access(OP_QUERY, s, $urandom_range(0, WAYS - 1));
            sent += n + 1;
         end else begin
            send_access(op_type'($urandom_range(0, 3)), $urandom_range(0, SETS - 1),
                        $urandom_range(0, WAYS - 1));
            sent++;
         end
      end
   endtask

   // directed accesses under reset settings
   task automatic test_reset_defaults();
      send_access(OP_QUERY, 0, 0);
      send_access(OP_QUERY, 63, 15);
      send_access(OP_TOUCH, 63, 15);   // touch of an invalid way
      send_access(OP_INSERT, 63, 0);
      send_access(OP_TOUCH, 63, 15);   // promotion toward most recent
      send_access(OP_QUERY, 63, 0);
      send_access(OP_INSERT, 63, 1);
      send_access(OP_INSERT, 63, 2);
      send_access(OP_INSERT, 63, 3);
      send_access(OP_TOUCH, 63, 3);
      send_access(OP_INVAL, 63, 15);
      send_access(OP_QUERY, 63, 5);
      send_access(OP_INVAL, 0, 0);     // invalidate an already invalid way
      send_access(OP_INSERT, 0, 15);
      send_access(OP_TOUCH, 0, 15);
      send_access(OP_QUERY, 0, 10);
      send_access(OP_INSERT, 42, 10);
      send_access(OP_TOUCH, 21, 5);
      send_access(OP_QUERY, 21, 0);
      send_access(OP_QUERY, 42, 0);
   endtask

   // every promotion target the oldest position, then oldest insertion
   task automatic test_older_targets();
      apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      for (int w = 0; w < 4; w++) send_access(OP_INSERT, 5, w);
      send_access(OP_TOUCH, 5, 3);
      send_access(OP_QUERY, 5, 0);
      send_access(OP_TOUCH, 5, 0);
      send_access(OP_QUERY, 5, 0);
      apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd15);
      run_random_traffic(150);
   endtask

   // all targets most recent and insertion at the head: strict lru
   task automatic test_strict_lru();
      apply_settings(32'd0, 32'd0, 32'd0);
      no_idle = 1'b1;
      run_random_traffic(100);
      no_idle = 1'b0;
      run_random_traffic(150);
   endtask

   task automatic test_random_settings();
      for (int ph = 0; ph < 4; ph++) begin
         apply_settings($urandom(), $urandom(), $urandom_range(0, 15));
         run_random_traffic(220);
      end
   endtask

   // long response stall while requests keep coming
   task automatic test_backpressure();
      wait_for_results();
      no_idle = 1'b1;
      hold_request = 1'b1;
      for (int k = 0; k < 20; k++)
         send_access(pick_op(), busy_sets[k % 2], $urandom_range(0, WAYS - 1));
      wait_for_results();
      no_idle = 1'b0;
   endtask

   task automatic test_restored_defaults();
      apply_settings(PROMOTE_LOW_RST, PROMOTE_HIGH_RST, 32'(INSERT_POS_RST));
      run_random_traffic(300);
   endtask

   // response side: random stalls, long hold on request
   initial begin
      int stall_left;
      int r;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (no_idle) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 20) begin
               rsp_bus.ready <= 1'b0;
               stall_left = $urandom_range(0, 2);
            end else if (r < 23) begin
               rsp_bus.ready <= 1'b0;
               stall_left = $urandom_range(10, 40);
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // response checker
   always @(posedge clock) begin
      victim_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         rsp_count++;
         if (victims_due.size() == 0) begin
            report_mismatch("unexpected response", 32'd0, 32'(rsp_bus.victim_way));
         end else begin
            want = victims_due.pop_front();
            if (rsp_bus.victim_way !== want.way)
               report_mismatch("victim_way", 32'(want.way), 32'(rsp_bus.victim_way));
            if (rsp_bus.victim_position !== want.position)
               report_mismatch("victim_position", 32'(want.position),
                               32'(rsp_bus.victim_position));
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // test sequence
   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.op        <= OP_TOUCH;
      req_bus.set_index <= '0;
      req_bus.way       <= '0;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= CSR_PROMOTE_LOW;
      csr_bus.data      <= '0;
      promote_lo_q = PROMOTE_LOW_RST;
      promote_hi_q = PROMOTE_HIGH_RST;
      insert_pos_q = INSERT_POS_RST;
      foreach (recency[s, w]) recency[s][w] = POS_INVALID;
      foreach (busy_sets[i]) busy_sets[i] = i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_older_targets();
      test_strict_lru();
      test_backpressure();
      test_random_settings();
      test_restored_defaults();

      wait_for_results();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
